### hw/rtl/utce_pkg.sv
// Shared types, widths and calendar tables for the UTC date to epoch seconds block.
// No dependencies; used by every module in hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package utce_pkg;

   // Field widths
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int EPOCH_W = 32;

   // Internal widths: whole-year days up to year 4095, days before a month, year / 100
   localparam int YDAYS_W = 20;
   localparam int MDAYS_W = 9;
   localparam int Q100_W  = 6;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR      = 12'd1970;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam int                 DAYS_PER_YEAR   = 365;
   localparam int                 YEARS_PER_CENT  = 100;

   // Leap years in 1..1969: 1969/4 - 1969/100 + 1969/400
   localparam logic [YDAYS_W-1:0] LEAPS_BEFORE_EPOCH = 20'd477;

   // floor(y / 100) = (y * 5243) >> 19, exact for y below 43690
   localparam int                 RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
   localparam int                 RECIP_SHIFT = 19;

   // Days before each month, for 0..12 whole months
   localparam logic [MDAYS_W-1:0] DAYS_BEFORE_NORMAL [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam logic [MDAYS_W-1:0] DAYS_BEFORE_LEAP [13] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };

   // Request in flight after the day count is known
   typedef struct packed {
      logic               valid;
      logic [EPOCH_W-1:0] days;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } day_item_type;

endpackage

`default_nettype wire

### hw/rtl/utce_day_count.sv
// Day count pipeline: year / 100, leap rule, whole-year and whole-month days.
// Depends on utce_pkg. Three register stages.
`timescale 1ns / 1ps
`default_nettype none

module utce_day_count (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [utce_pkg::YEAR_W-1:0]   req_year,
   input  wire logic [utce_pkg::MONTH_W-1:0]  req_month_index,
   input  wire logic [utce_pkg::DAY_W-1:0]    req_day_of_month,
   input  wire logic [utce_pkg::HOUR_W-1:0]   req_hour,
   input  wire logic [utce_pkg::MIN_W-1:0]    req_minute,
   input  wire logic [utce_pkg::SEC_W-1:0]    req_second,
   output utce_pkg::day_item_type             day_item
);

   localparam int YW   = utce_pkg::YEAR_W;
   localparam int MW   = utce_pkg::MONTH_W;
   localparam int DW   = utce_pkg::DAY_W;
   localparam int HW   = utce_pkg::HOUR_W;
   localparam int NW   = utce_pkg::MIN_W;
   localparam int SW   = utce_pkg::SEC_W;
   localparam int EW   = utce_pkg::EPOCH_W;
   localparam int YDW  = utce_pkg::YDAYS_W;
   localparam int MDW  = utce_pkg::MDAYS_W;
   localparam int QW   = utce_pkg::Q100_W;
   localparam int RW   = utce_pkg::RECIP_W;
   localparam int PW   = YW + RW;

   // ---------------- stage 1: year / 100 by reciprocal, clamp month
   logic [PW-1:0] q_prod;
   logic [QW-1:0] q100_in;
   logic [MW-1:0] mon_in;

   logic          v1_ff;
   logic [YW-1:0] year1_ff;
   logic [QW-1:0] q100_1_ff;
   logic [MW-1:0] mon1_ff;
   logic [DW-1:0] mday1_ff;
   logic [HW-1:0] hour1_ff;
   logic [NW-1:0] min1_ff;
   logic [SW-1:0] sec1_ff;

   always_comb begin
      q_prod  = PW'(req_year) * PW'(utce_pkg::RECIP_100);
      q100_in = q_prod[utce_pkg::RECIP_SHIFT +: QW];
      mon_in  = (req_month_index > utce_pkg::MONTHS_PER_YEAR) ?
                utce_pkg::MONTHS_PER_YEAR : req_month_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      year1_ff  <= req_year;
      q100_1_ff <= q100_in;
      mon1_ff   <= mon_in;
      mday1_ff  <= req_day_of_month;
      hour1_ff  <= req_hour;
      min1_ff   <= req_minute;
      sec1_ff   <= req_second;
   end

   // ---------------- stage 2: leap rule, whole-year days, whole-month days
   logic [YW-1:0]  rem100;
   logic           div100;
   logic           div400;
   logic           leap;
   logic [YW-1:0]  year_prev;
   logic [YW-1:0]  leaps_prev;
   logic [YW-1:0]  span;
   logic [YDW-1:0] ydays_raw;
   logic [YDW-1:0] ydays_in;
   logic [MDW-1:0] mdays_in;

   logic           v2_ff;
   logic [YDW-1:0] ydays2_ff;
   logic [MDW-1:0] mdays2_ff;
   logic [DW-1:0]  mday2_ff;
   logic [HW-1:0]  hour2_ff;
   logic [NW-1:0]  min2_ff;
   logic [SW-1:0]  sec2_ff;

   always_comb begin
      rem100 = year1_ff - YW'(YW'(q100_1_ff) * YW'(utce_pkg::YEARS_PER_CENT));
      div100 = (rem100 == '0);
      div400 = div100 && (q100_1_ff[1:0] == 2'b00);
      leap   = (year1_ff[1:0] == 2'b00) && (!div100 || div400);

      // leap years in 1..year-1, from year / 100 corrected for the year itself
      year_prev  = year1_ff - YW'(1);
      leaps_prev = (year_prev >> 2)
                 - (YW'(q100_1_ff) - YW'(div100))
                 + (YW'(q100_1_ff >> 2) - YW'(div400));

      span      = year1_ff - utce_pkg::EPOCH_YEAR;
      ydays_raw = YDW'(span) * YDW'(utce_pkg::DAYS_PER_YEAR)
                + YDW'(leaps_prev) - utce_pkg::LEAPS_BEFORE_EPOCH;
      ydays_in  = (year1_ff > utce_pkg::EPOCH_YEAR) ? ydays_raw : '0;

      mdays_in  = leap ? utce_pkg::DAYS_BEFORE_LEAP[mon1_ff]
                       : utce_pkg::DAYS_BEFORE_NORMAL[mon1_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ydays2_ff <= ydays_in;
      mdays2_ff <= mdays_in;
      mday2_ff  <= mday1_ff;
      hour2_ff  <= hour1_ff;
      min2_ff   <= min1_ff;
      sec2_ff   <= sec1_ff;
   end

   // ---------------- stage 3: total day count, day of month counts from 1
   logic [EW-1:0]          days_in;
   utce_pkg::day_item_type item_ff;

   always_comb begin
      days_in = EW'(ydays2_ff) + EW'(mdays2_ff) + EW'(mday2_ff) - EW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= v2_ff;
      end
      item_ff.days   <= days_in;
      item_ff.hour   <= hour2_ff;
      item_ff.minute <= min2_ff;
      item_ff.second <= sec2_ff;
   end

   assign day_item = item_ff;

   // Reciprocal divide must leave a remainder below 100
   a_rem100_range : assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (rem100 < YW'(utce_pkg::YEARS_PER_CENT)))
      else $error("year / 100 reciprocal gave an out-of-range remainder");

   // Years up to the epoch contribute no whole-year days
   a_pre_epoch_zero : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && (year1_ff <= utce_pkg::EPOCH_YEAR)) |=> (ydays2_ff == '0))
      else $error("whole-year days nonzero at or before the epoch year");

endmodule

`default_nettype wire

### hw/rtl/utce_sec_scale.sv
// Scaling pipeline: days to hours, minutes and seconds, one constant multiply a stage.
// Depends on utce_pkg. Three register stages, the last drives the result ports.
`timescale 1ns / 1ps
`default_nettype none

module utce_sec_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire utce_pkg::day_item_type        day_item,
   output logic                               rsp_valid,
   output logic [utce_pkg::EPOCH_W-1:0]       rsp_epoch_seconds
);

   localparam int EW = utce_pkg::EPOCH_W;
   localparam int NW = utce_pkg::MIN_W;
   localparam int SW = utce_pkg::SEC_W;

   // ---------------- stage 4: hours
   logic          v4_ff;
   logic [EW-1:0] hours_ff;
   logic [NW-1:0] min4_ff;
   logic [SW-1:0] sec4_ff;
   logic [EW-1:0] hours_in;

   assign hours_in = day_item.days * EW'(24) + EW'(day_item.hour);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= day_item.valid;
      end
   end

   always_ff @(posedge clock) begin
      hours_ff <= hours_in;
      min4_ff  <= day_item.minute;
      sec4_ff  <= day_item.second;
   end

   // ---------------- stage 5: minutes
   logic          v5_ff;
   logic [EW-1:0] mins_ff;
   logic [SW-1:0] sec5_ff;
   logic [EW-1:0] mins_in;

   assign mins_in = hours_ff * EW'(60) + EW'(min4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      mins_ff <= mins_in;
      sec5_ff <= sec4_ff;
   end

   // ---------------- stage 6: seconds, result register
   logic          v6_ff;
   logic [EW-1:0] secs_ff;
   logic [EW-1:0] secs_in;

   assign secs_in = mins_ff * EW'(60) + EW'(sec5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      secs_ff <= secs_in;
   end

   assign rsp_valid         = v6_ff;
   assign rsp_epoch_seconds = secs_ff;

endmodule

`default_nettype wire

### hw/rtl/utc_date_to_epoch_seconds.sv
// Top level of the UTC date to epoch seconds converter.
// Depends on utce_pkg, utce_day_count and utce_sec_scale.
`timescale 1ns / 1ps
`default_nettype none

// Converts a broken-down UTC date and time into seconds since 1970-01-01 00:00:00,
// leap seconds ignored, with the Gregorian leap rule. Nothing is validated: an
// out-of-range day, hour, minute or second simply adds on, a month index above 11
// counts the whole year, years up to 1970 add no year days, and the total wraps
// modulo 2^32. A request is taken on every cycle that start is high (busy is always
// low), and its result appears on rsp_epoch_seconds with the rsp_valid strobe for
// one cycle, in request order, after it has passed through the six-stage pipeline
// (three for the day count, three for the hour/minute/second scaling); throughput
// is one request per clock. The receiver cannot stall results.
module utc_date_to_epoch_seconds (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [utce_pkg::YEAR_W-1:0]   req_year,
   input  wire logic [utce_pkg::MONTH_W-1:0]  req_month_index,
   input  wire logic [utce_pkg::DAY_W-1:0]    req_day_of_month,
   input  wire logic [utce_pkg::HOUR_W-1:0]   req_hour,
   input  wire logic [utce_pkg::MIN_W-1:0]    req_minute,
   input  wire logic [utce_pkg::SEC_W-1:0]    req_second,
   output logic                               rsp_valid,
   output logic [utce_pkg::EPOCH_W-1:0]       rsp_epoch_seconds
);

   utce_pkg::day_item_type day_item;
   logic                   req_take;

   // Accept a request every cycle: the pipeline never holds
   assign busy     = 1'b0;
   assign req_take = start && !busy;

   utce_day_count u_day_count (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_take),
      .req_year         (req_year),
      .req_month_index  (req_month_index),
      .req_day_of_month (req_day_of_month),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_second       (req_second),
      .day_item         (day_item)
   );

   utce_sec_scale u_sec_scale (
      .clock             (clock),
      .reset             (reset),
      .day_item          (day_item),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   // Every accepted request yields a result once it leaves the pipeline
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##6 rsp_valid)
      else $error("accepted request produced no result after six cycles");

   // No result without a matching earlier request
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, 6))
      else $error("result strobe without a matching request");

endmodule

`default_nettype wire
